[rtl/core/spq_pkg.sv]
// ----------------------------------------------------------------------------
// spq_pkg
// Shared constants, codes and control types of the strict-priority queues.
// ----------------------------------------------------------------------------
package spq_pkg;

	// Geometry
	localparam int QUEUE_DEPTH = 8;
	localparam int LEVELS      = 4;
	localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int LVL_W       = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	// Field widths
	localparam int PRIO_W    = 2;
	localparam int NAME_LO_W = 64;
	localparam int NAME_HI_W = 8;
	localparam int STATUS_W  = 2;

	// Request codes
	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_POP  = 1'b1;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

	// Controller to datapath
	typedef struct packed {
		logic load;     // request accepted: load the result register
		logic do_push;  // write the name and advance the tail
		logic do_pop;   // read the oldest entry and advance the head
	} spq_ctl_t;

	// Datapath to controller
	typedef struct packed {
		logic push_ok;  // presented request is a push that fits
		logic pop_ok;   // presented request is a pop with something queued
	} spq_stat_t;

endpackage

[rtl/core/spq_ctrl.sv]
// ----------------------------------------------------------------------------
// spq_ctrl
// Handshake controller: accepts requests and holds the result until taken.
// ----------------------------------------------------------------------------
module spq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  logic               out_stall,
	input  spq_pkg::spq_stat_t stat,
	output spq_pkg::spq_ctl_t  ctl
);
	import spq_pkg::*;

	localparam logic S_IDLE = 1'b0;
	localparam logic S_OUT  = 1'b1;

	logic state_q;
	logic state_d;
	logic accept;

	// Stall input only while a result is held and the sink is stalled
	assign in_stall  = (state_q == S_OUT) && out_stall;
	assign out_valid = (state_q == S_OUT);
	assign accept    = in_valid && !in_stall;

	assign ctl.load    = accept;
	assign ctl.do_push = accept && stat.push_ok;
	assign ctl.do_pop  = accept && stat.pop_ok;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				if (accept) begin
					state_d = S_OUT;
				end else if (!out_stall) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// An accepted request always shows a result on the next cycle
	a_accept_shows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid)
		else $error("spq_ctrl: accepted request left no result");

endmodule

[rtl/core/spq_datapath.sv]
// ----------------------------------------------------------------------------
// spq_datapath
// Ring storage, per-level pointers and counts, level search, result register.
// ----------------------------------------------------------------------------
module spq_datapath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cmd,
	input  logic [spq_pkg::PRIO_W-1:0]      priority_req,
	input  logic [spq_pkg::NAME_LO_W-1:0]   name_lo,
	input  logic [spq_pkg::NAME_HI_W-1:0]   name_hi,
	input  spq_pkg::spq_ctl_t               ctl,
	output spq_pkg::spq_stat_t              stat,
	output logic [spq_pkg::STATUS_W-1:0]    status,
	output logic [spq_pkg::PRIO_W-1:0]      served_level,
	output logic [spq_pkg::NAME_LO_W-1:0]   out_name_lo,
	output logic [spq_pkg::NAME_HI_W-1:0]   out_name_hi
);
	import spq_pkg::*;

	logic [NAME_LO_W-1:0] mem_lo [LEVELS][QUEUE_DEPTH];
	logic [NAME_HI_W-1:0] mem_hi [LEVELS][QUEUE_DEPTH];

	logic [IDX_W-1:0] head_q [LEVELS];
	logic [IDX_W-1:0] tail_q [LEVELS];
	logic [CNT_W-1:0] occ_q  [LEVELS];

	logic [STATUS_W-1:0]  status_q;
	logic [PRIO_W-1:0]    served_q;
	logic [NAME_LO_W-1:0] out_lo_q;
	logic [NAME_HI_W-1:0] out_hi_q;

	logic             in_range;
	logic [LVL_W-1:0] push_lvl;
	logic [LVL_W-1:0] pop_lvl;
	logic             any_busy;

	function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
		return (idx == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : idx + 1'b1;
	endfunction

	assign in_range = (32'(priority_req) < LEVELS);
	assign push_lvl = LVL_W'(priority_req);

	// Highest non-empty level wins
	always_comb begin
		pop_lvl  = '0;
		any_busy = 1'b0;
		for (int l = 0; l < LEVELS; l++) begin
			if (occ_q[l] != '0) begin
				pop_lvl  = LVL_W'(l);
				any_busy = 1'b1;
			end
		end
	end

	assign stat.push_ok = (cmd == CMD_PUSH) && in_range
		&& (occ_q[push_lvl] != CNT_W'(QUEUE_DEPTH));
	assign stat.pop_ok  = (cmd == CMD_POP) && any_busy;

	// Pointers and counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l < LEVELS; l++) begin
				head_q[l] <= '0;
				tail_q[l] <= '0;
				occ_q[l]  <= '0;
			end
		end else begin
			if (ctl.do_push) begin
				tail_q[push_lvl] <= ring_next(tail_q[push_lvl]);
				occ_q[push_lvl]  <= occ_q[push_lvl] + 1'b1;
			end
			if (ctl.do_pop) begin
				head_q[pop_lvl] <= ring_next(head_q[pop_lvl]);
				occ_q[pop_lvl]  <= occ_q[pop_lvl] - 1'b1;
			end
		end
	end

	// Ring storage write port
	always_ff @(posedge clk) begin
		if (ctl.do_push) begin
			mem_lo[push_lvl][tail_q[push_lvl]] <= name_lo;
			mem_hi[push_lvl][tail_q[push_lvl]] <= name_hi;
		end
	end

	// Read port lands straight in the result register
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			if (ctl.do_pop) begin
				out_lo_q <= mem_lo[pop_lvl][head_q[pop_lvl]];
				out_hi_q <= mem_hi[pop_lvl][head_q[pop_lvl]];
				served_q <= PRIO_W'(pop_lvl);
				status_q <= ST_OK;
			end else begin
				out_lo_q <= '0;
				out_hi_q <= '0;
				served_q <= '0;
				if (ctl.do_push) begin
					status_q <= ST_OK;
				end else if (cmd == CMD_PUSH) begin
					status_q <= ST_OVERFLOW;
				end else begin
					status_q <= ST_UNDERFLOW;
				end
			end
		end
	end

	assign status       = status_q;
	assign served_level = served_q;
	assign out_name_lo  = out_lo_q;
	assign out_name_hi  = out_hi_q;

	a_one_op: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.do_push && ctl.do_pop))
		else $error("spq_datapath: push and pop in one cycle");

	a_pop_ok: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.do_pop |=> (status_q == ST_OK))
		else $error("spq_datapath: served pop without ok status");

	a_reject_flagged: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.load && !ctl.do_push && !ctl.do_pop) |=> (status_q != ST_OK))
		else $error("spq_datapath: rejected request reported ok");

endmodule

[rtl/core/strict_priority_ring_queues.sv]
// ----------------------------------------------------------------------------
// strict_priority_ring_queues
// Four circular name queues served in strict priority order.
// ----------------------------------------------------------------------------
// Each request is a push (cmd 0) of a nine-byte name to the queue of level
// priority_req, or a pop (cmd 1) of the oldest name from the highest
// non-empty level (level 3 is the highest). Every request returns exactly
// one result, in the cycle after it is accepted: status ok, overflow (push
// to a full queue, name dropped) or underflow (pop with all queues empty),
// plus the served level and name on a successful pop, zeros otherwise. The
// block sustains one request per cycle while out_stall is low: a push
// touches one ring slot and one counter, a pop reads one ring slot whose
// read port loads the result register directly. in_stall rises only while
// a result is held and out_stall is high. Reset clears head, tail and
// occupancy counts but not ring contents, so it is usable right after reset.
module strict_priority_ring_queues (
	input  logic                            clk,
	input  logic                            arst_n,
	// Request channel
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            cmd,
	input  logic [spq_pkg::PRIO_W-1:0]      priority_req,
	input  logic [spq_pkg::NAME_LO_W-1:0]   name_lo,
	input  logic [spq_pkg::NAME_HI_W-1:0]   name_hi,
	// Result channel
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [spq_pkg::STATUS_W-1:0]    status,
	output logic [spq_pkg::PRIO_W-1:0]      served_level,
	output logic [spq_pkg::NAME_LO_W-1:0]   out_name_lo,
	output logic [spq_pkg::NAME_HI_W-1:0]   out_name_hi
);
	import spq_pkg::*;

	spq_ctl_t  ctl;
	spq_stat_t stat;

	// Handshake and sequencing
	spq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.ctl       (ctl)
	);

	// Storage, pointers, level search and result register
	spq_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.priority_req (priority_req),
		.name_lo      (name_lo),
		.name_hi      (name_hi),
		.ctl          (ctl),
		.stat         (stat),
		.status       (status),
		.served_level (served_level),
		.out_name_lo  (out_name_lo),
		.out_name_hi  (out_name_hi)
	);

endmodule
